// ===== rtl/dgrc_pkg.sv =====
// Shared types and constants for the grid ray caster.
package dgrc_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   localparam logic [1:0] FACE_EAST  = 2'd0;
   localparam logic [1:0] FACE_WEST  = 2'd1;
   localparam logic [1:0] FACE_NORTH = 2'd2;
   localparam logic [1:0] FACE_SOUTH = 2'd3;

   // Config register indexes.
   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   // Side distances: Q16.16 with headroom for about 256 steps per axis at the
   // no-direction delta (2^40).
   localparam int SIDE_W = 48;
   localparam int DIV_W  = 31;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;       // Capture the cast item.
      logic div_start;  // Start a reciprocal.
      logic div_sel_y;  // Reciprocal for the y component.
      logic div_step;   // One restoring-divide step.
      logic div_save;   // Store the reciprocal.
      logic mul_x;      // Start side distance in x.
      logic mul_y;      // Start side distance in y.
      logic walk;       // Take one DDA step.
      logic test;       // Check the cell read from the map.
      logic finish;     // Register the result item.
   } dgrc_cmd_type;

   // Datapath status to controller.
   typedef struct packed {
      logic out_of_map;
      logic is_hit;
   } dgrc_stat_type;

endpackage

// ===== rtl/dgrc_ctrl.sv =====
// Controller state machine for the grid ray caster.
module dgrc_ctrl
   import dgrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          command,
   input  dgrc_stat_type stat,
   output logic          busy,
   output dgrc_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIVX, ST_SAVEX, ST_DIVY, ST_SAVEY, ST_MULX, ST_MULY,
      ST_WALK, ST_READ, ST_TEST, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   // Next-state logic and command decode.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && command == CMD_CAST) begin
               cmd.load = 1'b1;
               state_in = ST_DIVX;
               cnt_in = '0;
            end
         end
         ST_DIVX, ST_DIVY: begin
            cmd.div_sel_y = (state_ff == ST_DIVY);
            if (cnt_ff == '0) cmd.div_start = 1'b1;
            else cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_W)) begin
               state_in = (state_ff == ST_DIVX) ? ST_SAVEX : ST_SAVEY;
            end
         end
         ST_SAVEX: begin
            cmd.div_save = 1'b1;
            cnt_in = '0;
            state_in = ST_DIVY;
         end
         ST_SAVEY: begin
            cmd.div_save = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in = ST_MULX;
         end
         ST_MULX: begin
            cmd.mul_x = 1'b1;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            cmd.mul_y = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            // Map read data is registered; wait for it in this state, or leave the map.
            if (stat.out_of_map) state_in = ST_DONE;
            else state_in = ST_TEST;
         end
         ST_TEST: begin
            cmd.test = 1'b1;
            if (stat.is_hit) state_in = ST_DONE;
            else state_in = ST_WALK;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/dgrc_datapath.sv =====
// Datapath for the grid ray caster: map store, reciprocal, DDA walk and result.
module dgrc_datapath
   import dgrc_pkg::*;
#(
   parameter int MAP_SIDE = 64,
   parameter int POS_FRAC_BITS = 16,
   parameter int ADDR_W = 12
)(
   input  logic               clock,
   input  logic               reset,
   input  dgrc_cmd_type       cmd,
   output dgrc_stat_type      stat,
   input  logic               wr_en,
   input  logic [5:0]         cell_col,
   input  logic [5:0]         cell_row,
   input  logic [7:0]         tile_in,
   input  logic               solid_in,
   input  logic [21:0]        pos_x,
   input  logic [21:0]        pos_y,
   input  logic signed [15:0] dir_x,
   input  logic signed [15:0] dir_y,
   input  logic [6:0]         map_width,
   input  logic [6:0]         map_height,
   output logic               rsp_valid,
   output logic               hit,
   output logic [31:0]        distance,
   output logic [5:0]         hit_col,
   output logic [5:0]         hit_row,
   output logic [11:0]        hit_index,
   output logic [7:0]         hit_tile,
   output logic [1:0]         face
);

   localparam int SIDE_IDX_W = $clog2(MAP_SIDE);
   localparam int INT_W = 22 - POS_FRAC_BITS;
   localparam int MC_W = 12;
   localparam int PROD_W = POS_FRAC_BITS + DIV_W + 1;
   localparam logic [SIDE_W-1:0] DELTA_INF = SIDE_W'(64'd1 << 40);
   localparam logic [POS_FRAC_BITS:0] ONE = (POS_FRAC_BITS+1)'(1) << POS_FRAC_BITS;

   // Map store: bit 8 solid, bits 7..0 tile.
   logic [8:0] store [MAP_SIDE*MAP_SIDE];
   logic [8:0] rd_ff;

   logic [POS_FRAC_BITS-1:0] fx_ff, fy_ff;
   logic neg_x_ff, neg_y_ff, zero_x_ff, zero_y_ff;
   logic [15:0] ax_ff, ay_ff;
   logic [SIDE_W-1:0] dx_d_ff, dy_d_ff, sx_ff, sy_ff;
   logic signed [MC_W-1:0] mx_ff, my_ff, lastx_ff, lasty_ff;
   logic side_y_ff;
   logic [6:0] w_ff, h_ff;

   // Restoring divider for 2^30 / a.
   logic [DIV_W-1:0] quo_ff, rem_ff;
   logic [DIV_W:0] rem_sh;
   logic [15:0] div_a;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
   end
   assign div_a = cmd.div_sel_y ? ay_ff : ax_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= DIV_W'(32'd1 << 30);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {16'd0, div_a}) begin
            rem_ff <= DIV_W'(rem_sh - {16'd0, div_a});
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   // Start side distance. A nonzero component has a reciprocal below 2^31, so the
   // multiply is fraction by reciprocal; the no-direction delta is a plain shift.
   logic [POS_FRAC_BITS:0] f_sel;
   logic [DIV_W-1:0] d_sel;
   logic z_sel;
   logic [PROD_W-1:0] prod;
   logic [SIDE_W-1:0] start_side;
   always_comb begin
      if (cmd.mul_y) begin
         f_sel = neg_y_ff ? {1'b0, fy_ff} : ONE - {1'b0, fy_ff};
         d_sel = dy_d_ff[DIV_W-1:0];
         z_sel = zero_y_ff;
      end else begin
         f_sel = neg_x_ff ? {1'b0, fx_ff} : ONE - {1'b0, fx_ff};
         d_sel = dx_d_ff[DIV_W-1:0];
         z_sel = zero_x_ff;
      end
      prod = PROD_W'(f_sel) * PROD_W'(d_sel);
      if (z_sel) start_side = SIDE_W'(f_sel) << (40 - POS_FRAC_BITS);
      else start_side = SIDE_W'(prod >> POS_FRAC_BITS);
   end

   // Next cell and bounds.
   logic step_x;
   logic signed [MC_W-1:0] nmx, nmy;
   logic in_map;
   assign step_x = (sx_ff < sy_ff);
   assign nmx = step_x ? (neg_x_ff ? mx_ff - MC_W'(1) : mx_ff + MC_W'(1)) : mx_ff;
   assign nmy = step_x ? my_ff : (neg_y_ff ? my_ff - MC_W'(1) : my_ff + MC_W'(1));
   assign in_map = (mx_ff >= 0) && (my_ff >= 0) &&
                   (mx_ff < $signed({5'd0, w_ff})) && (my_ff < $signed({5'd0, h_ff}));

   assign stat.out_of_map = !in_map;
   assign stat.is_hit = rd_ff[8] && (rd_ff[7:0] != 8'd0);

   // Effective map sizes.
   function automatic logic [6:0] eff(input logic [6:0] v);
      if (v == 7'd0) return 7'd1;
      if (32'(v) > MAP_SIDE) return 7'(MAP_SIDE);
      return v;
   endfunction

   logic [SIDE_W-1:0] dist_w;
   assign dist_w = side_y_ff ? sy_ff - dy_d_ff : sx_ff - dx_d_ff;

   always_ff @(posedge clock) begin
      // Map write and registered read.
      if (wr_en && 32'(cell_col) < MAP_SIDE && 32'(cell_row) < MAP_SIDE) begin
         store[ADDR_W'(cell_row) * ADDR_W'(MAP_SIDE) + ADDR_W'(cell_col)] <=
            {solid_in, tile_in};
      end
      rd_ff <= store[ADDR_W'(my_ff[SIDE_IDX_W-1:0]) * ADDR_W'(MAP_SIDE) +
                     ADDR_W'(mx_ff[SIDE_IDX_W-1:0])];

      if (cmd.load) begin
         fx_ff <= pos_x[POS_FRAC_BITS-1:0];
         fy_ff <= pos_y[POS_FRAC_BITS-1:0];
         mx_ff <= MC_W'(pos_x[21 -: INT_W]);
         my_ff <= MC_W'(pos_y[21 -: INT_W]);
         lastx_ff <= MC_W'(pos_x[21 -: INT_W]);
         lasty_ff <= MC_W'(pos_y[21 -: INT_W]);
         neg_x_ff <= dir_x[15];
         neg_y_ff <= dir_y[15];
         zero_x_ff <= (dir_x == 16'sd0);
         zero_y_ff <= (dir_y == 16'sd0);
         ax_ff <= dir_x[15] ? 16'(-dir_x) : 16'(dir_x);
         ay_ff <= dir_y[15] ? 16'(-dir_y) : 16'(dir_y);
         w_ff <= eff(map_width);
         h_ff <= eff(map_height);
      end
      if (cmd.div_save) begin
         if (cmd.div_sel_y) dy_d_ff <= zero_y_ff ? DELTA_INF : SIDE_W'(quo_ff);
         else dx_d_ff <= zero_x_ff ? DELTA_INF : SIDE_W'(quo_ff);
      end
      if (cmd.mul_x) sx_ff <= start_side;
      if (cmd.mul_y) sy_ff <= start_side;
      if (cmd.walk) begin
         side_y_ff <= !step_x;
         if (step_x) sx_ff <= sx_ff + dx_d_ff;
         else sy_ff <= sy_ff + dy_d_ff;
         mx_ff <= nmx;
         my_ff <= nmy;
      end
      if (cmd.test) begin
         lastx_ff <= mx_ff;
         lasty_ff <= my_ff;
      end
   end

   // Result register.
   logic [MC_W-1:0] idx;
   always_comb begin
      idx = MC_W'(lasty_ff * $signed({5'd0, w_ff}) + lastx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= cmd.finish;
      if (cmd.finish) begin
         hit_col <= lastx_ff[5:0];
         hit_row <= lasty_ff[5:0];
         hit_index <= idx[11:0];
         if (in_map && stat.is_hit) begin
            hit <= 1'b1;
            hit_tile <= rd_ff[7:0];
            distance <= (dist_w[SIDE_W-1:32] != '0) ? 32'hFFFF_FFFF : dist_w[31:0];
            if (side_y_ff) face <= neg_y_ff ? FACE_NORTH : FACE_SOUTH;
            else face <= neg_x_ff ? FACE_EAST : FACE_WEST;
         end else begin
            hit <= 1'b0;
            hit_tile <= '0;
            distance <= '0;
            face <= FACE_EAST;
         end
      end
   end

endmodule

// ===== rtl/dda_grid_ray_cast.sv =====
// Top level of the grid ray caster.
// A write is stored at its accepting edge. A cast computes the x and y reciprocals
// in turn, saving each, then the x and y start side distances; it then walks cell by
// cell (step, map read, test) until it reaches a solid cell with a nonzero tile or
// leaves the map, and finishes; the result strobe follows. One item is taken at a time;
// busy stays high until the result strobe. The receiver cannot stall. Synchronous
// active-high reset sets the map size to 64 by 64; the map is not cleared.
module dda_grid_ray_cast
   import dgrc_pkg::*;
#(
   parameter int MAP_SIDE = 64,
   parameter int POS_FRAC_BITS = 16
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [5:0]         req_cell_col,
   input  logic [5:0]         req_cell_row,
   input  logic [7:0]         req_tile_in,
   input  logic               req_solid_in,
   input  logic [21:0]        req_pos_x,
   input  logic [21:0]        req_pos_y,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [31:0]        rsp_distance,
   output logic [5:0]         rsp_hit_col,
   output logic [5:0]         rsp_hit_row,
   output logic [11:0]        rsp_hit_index,
   output logic [7:0]         rsp_hit_tile,
   output logic [1:0]         rsp_face
);

   localparam int ADDR_W = 2 * $clog2(MAP_SIDE);

   dgrc_cmd_type  cmd;
   dgrc_stat_type stat;
   logic [6:0] width_ff, height_ff;
   logic wr_en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 7'd64;
         height_ff <= 7'd64;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  width_ff <= csr_wdata;
            CSR_MAP_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign wr_en = start && !busy && (req_command == CMD_WRITE);

   dgrc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start && !busy), .command(req_command),
      .stat(stat), .busy(busy), .cmd(cmd)
   );

   dgrc_datapath #(
      .MAP_SIDE(MAP_SIDE), .POS_FRAC_BITS(POS_FRAC_BITS), .ADDR_W(ADDR_W)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .wr_en(wr_en),
      .cell_col(req_cell_col), .cell_row(req_cell_row), .tile_in(req_tile_in),
      .solid_in(req_solid_in), .pos_x(req_pos_x), .pos_y(req_pos_y),
      .dir_x(req_dir_x), .dir_y(req_dir_y), .map_width(width_ff),
      .map_height(height_ff), .rsp_valid(rsp_valid), .hit(rsp_hit),
      .distance(rsp_distance), .hit_col(rsp_hit_col), .hit_row(rsp_hit_row),
      .hit_index(rsp_hit_index), .hit_tile(rsp_hit_tile), .face(rsp_face)
   );

`ifndef SYNTH
   // A result item only appears while a cast is in progress.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without cast");
   // A result is a single-cycle strobe.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe too long");
   // A miss carries zero distance.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_distance == 32'd0)) else $error("miss distance");
`endif

endmodule
